>>> hdl/tlcr_pkg.sv
// Shared types, constants and font lookup for the timecode LED column renderer.
// No dependencies.
`timescale 1ns / 1ps

package tlcr_pkg;

   localparam int FIELD_W   = 7;
   localparam int NUM_FLD   = 5;
   localparam int NUM_DIG   = 10;
   localparam int DIG_W     = 4;
   localparam int COL_IDX_W = 6;
   localparam int ROW_W     = 7;
   localparam int TC_W      = FIELD_W * NUM_FLD;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 16;

   localparam logic [FIELD_W-1:0] FIELD_MAX  = 7'd99;
   localparam logic [ROW_W-1:0]   SEP_COLON  = 7'h24;
   localparam logic [ROW_W-1:0]   SEP_DOT    = 7'h40;

   // layout columns holding the separator pixels
   localparam logic [COL_IDX_W-1:0] COLON_COL_A = 6'd12;
   localparam logic [COL_IDX_W-1:0] COLON_COL_B = 6'd25;
   localparam logic [COL_IDX_W-1:0] COLON_COL_C = 6'd38;
   localparam logic [COL_IDX_W-1:0] DOT_COL     = 6'd51;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic commit;
      logic advance;
   } tlcr_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic same;
      logic last;
   } tlcr_status_type;

   typedef logic [NUM_DIG-1:0][DIG_W-1:0] tlcr_digits_type;

   // first layout column of each digit
   function automatic logic [COL_IDX_W-1:0] digit_start(input int k);
      logic [COL_IDX_W-1:0] s;
      unique case (k)
         0:       s = 6'd1;
         1:       s = 6'd6;
         2:       s = 6'd14;
         3:       s = 6'd19;
         4:       s = 6'd27;
         5:       s = 6'd32;
         6:       s = 6'd40;
         7:       s = 6'd45;
         8:       s = 6'd53;
         default: s = 6'd58;
      endcase
      return s;
   endfunction

   // 5x7 digit font, bit 0 top row
   function automatic logic [ROW_W-1:0] font(input logic [DIG_W-1:0] d,
                                             input logic [2:0] c);
      logic [4:0][ROW_W-1:0] g;
      unique case (d)
         4'd0:    g = {7'h3E, 7'h45, 7'h49, 7'h51, 7'h3E};
         4'd1:    g = {7'h00, 7'h40, 7'h7F, 7'h42, 7'h00};
         4'd2:    g = {7'h46, 7'h49, 7'h49, 7'h49, 7'h72};
         4'd3:    g = {7'h31, 7'h4B, 7'h45, 7'h41, 7'h21};
         4'd4:    g = {7'h08, 7'h7F, 7'h08, 7'h08, 7'h0F};
         4'd5:    g = {7'h39, 7'h45, 7'h45, 7'h45, 7'h27};
         4'd6:    g = {7'h38, 7'h45, 7'h45, 7'h45, 7'h3A};
         4'd7:    g = {7'h07, 7'h09, 7'h71, 7'h01, 7'h01};
         4'd8:    g = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
         4'd9:    g = {7'h3E, 7'h49, 7'h49, 7'h49, 7'h26};
         default: g = '0;
      endcase
      return (c < 3'd5) ? g[c] : '0;
   endfunction

endpackage

>>> hdl/tlcr_ctrl.sv
// Controller FSM for the timecode LED column renderer.
// Depends on tlcr_pkg.
`timescale 1ns / 1ps

module tlcr_ctrl import tlcr_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   input  tlcr_status_type status,
   output tlcr_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SEND
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;
   logic      valid_ff, valid_in;

   always_comb begin
      state_in    = state_ff;
      ready_in    = ready_ff;
      valid_in    = valid_ff;
      cmd.load    = 1'b0;
      cmd.commit  = 1'b0;
      cmd.advance = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            ready_in = 1'b1;
            if (ready_ff && req_tvalid) begin
               cmd.load = 1'b1;
               ready_in = 1'b0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.same) begin
               ready_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cmd.commit = 1'b1;
               valid_in   = 1'b1;
               state_in   = ST_SEND;
            end
         end
         ST_SEND: begin
            if (rsp_tready) begin
               cmd.advance = 1'b1;
               if (status.last) begin
                  valid_in = 1'b0;
                  ready_in = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         valid_ff <= valid_in;
      end
   end

   assign req_tready = ready_ff;
   assign rsp_tvalid = valid_ff;

endmodule

>>> hdl/tlcr_datapath.sv
// Datapath: saturation, repeat check, digit split, column counter and glyph lookup.
// Depends on tlcr_pkg.
`timescale 1ns / 1ps

module tlcr_datapath import tlcr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  tlcr_cmd_type          cmd,
   output tlcr_status_type       status,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   logic [TC_W-1:0]      pend_ff, pend_in;
   logic [TC_W-1:0]      shown_ff;
   logic                 shown_valid_ff;
   tlcr_digits_type      digits_ff, digits_in;
   logic [COL_IDX_W-1:0] cnt_ff;
   logic [COL_IDX_W-1:0] lc;
   logic [ROW_W-1:0]     bits;

   // saturate each field, days ends up in the top bits
   always_comb begin
      logic [FIELD_W-1:0] v;
      for (int k = 0; k < NUM_FLD; k++) begin
         v = req_tdata[k*FIELD_W +: FIELD_W];
         pend_in[(NUM_FLD-1-k)*FIELD_W +: FIELD_W] = (v > FIELD_MAX) ? FIELD_MAX : v;
      end
   end

   // tens = v*205 >> 11, exact for v <= 99
   always_comb begin
      logic [FIELD_W-1:0] v;
      logic [14:0]        prod;
      logic [DIG_W-1:0]   tens;
      logic [FIELD_W-1:0] tens_x10;
      for (int k = 0; k < NUM_FLD; k++) begin
         v        = pend_ff[(NUM_FLD-1-k)*FIELD_W +: FIELD_W];
         prod     = {8'd0, v} * 15'd205;
         tens     = prod[14:11];
         tens_x10 = {tens, 3'd0} + {2'd0, tens, 1'b0};
         digits_in[2*k]   = tens;
         digits_in[2*k+1] = DIG_W'(v - tens_x10);
      end
   end

   assign status.same = shown_valid_ff && (pend_ff == shown_ff);
   assign status.last = (cnt_ff == {COL_IDX_W{1'b1}});

   always_ff @(posedge clock) begin
      if (reset) begin
         shown_ff       <= '0;
         shown_valid_ff <= 1'b0;
         cnt_ff         <= '0;
      end else begin
         if (cmd.commit) begin
            shown_ff       <= pend_ff;
            shown_valid_ff <= 1'b1;
            cnt_ff         <= '0;
         end else if (cmd.advance) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pend_ff <= pend_in;
      end
      if (cmd.commit) begin
         digits_ff <= digits_in;
      end
   end

   // position i shows layout column 63-i
   assign lc = ~cnt_ff;

   always_comb begin
      logic [COL_IDX_W-1:0] off;
      off  = '0;
      bits = '0;
      if (lc == COLON_COL_A || lc == COLON_COL_B || lc == COLON_COL_C) begin
         bits = SEP_COLON;
      end else if (lc == DOT_COL) begin
         bits = SEP_DOT;
      end else begin
         for (int k = 0; k < NUM_DIG; k++) begin
            off = lc - digit_start(k);
            if (lc >= digit_start(k) && off < COL_IDX_W'(5)) begin
               bits = font(digits_ff[k], off[2:0]);
            end
         end
      end
   end

   assign rsp_tdata = {3'd0, bits, cnt_ff};
   assign rsp_tlast = status.last;

endmodule

>>> hdl/timecode_led_column_renderer.sv
// Top level of the timecode LED column renderer.
// Depends on tlcr_pkg, tlcr_ctrl and tlcr_datapath.
`timescale 1ns / 1ps

// Renders a timecode dd:hh:mm:ss.ff as 64 column bytes for a 7-row LED matrix,
// one column transfer per cycle while rsp_tready is high, column 0 first
// (rightmost layout column). Fields above 99 are shown as 99. A timecode equal
// to the last rendered one produces no output. An item is loaded and checked,
// then sent as 64 columns set by the column counter; a repeat ends at the check.
// The next timecode is taken once the last column transfer is done.
module timecode_led_column_renderer import tlcr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [6:0] days, [13:7] hours, [20:14] minutes, [27:21] seconds, [34:28] frames
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [5:0] column_index, [12:6] column_bits
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   tlcr_cmd_type    cmd;
   tlcr_status_type status;

   tlcr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tlcr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input accepted while columns pending");

   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> rsp_tdata[5:0] == 6'd0)
      else $error("frame does not start at column 0");

   a_col_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && rsp_tdata[5:0] == $past(rsp_tdata[5:0]) + 6'd1)
      else $error("column index skipped");

   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid)
      else $error("output continues after last column");
`endif

endmodule

>>> tb/tb_timecode_led_column_renderer.sv
// Self-checking testbench for timecode_led_column_renderer: queue-fed stream driver,
// rendering predictor and column checker. Depends on tlcr_pkg and the renderer RTL.
`timescale 1ns / 1ps

module tb_timecode_led_column_renderer;
   import tlcr_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int LONG_HOLD      = 400;
   localparam int LONG_HOLD_AT   = 700;
   localparam int TAIL_CYCLES    = 80;
   localparam int RANDOM_ITEMS   = 150;

   typedef logic [NUM_FLD-1:0][FIELD_W-1:0] timecode_type;   // [0] days .. [4] frames

   typedef struct packed {
      timecode_type fld;
      logic         drain;   // hold until all pending columns are out
   } tc_item_type;

   typedef struct packed {
      logic [COL_IDX_W-1:0] index;
      logic [ROW_W-1:0]     bits;
      logic                 last;
   } column_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   tc_item_type  pending_items[$];
   column_type   expected_columns[$];
   logic [TC_W-1:0] shown_tc = '0;
   logic            shown_ok = 1'b0;

   int req_sent      = 0;
   int req_accepts   = 0;
   int rsp_transfers = 0;
   int rsp_seen      = 0;
   int tx_gap        = 0;
   int rx_wait       = 0;
   int idle_cycles   = 0;
   int fails         = 0;

   timecode_led_column_renderer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one glyph column, columns listed left to right, bit 0 top row
   function automatic logic [ROW_W-1:0] glyph_column(input int dig, input int c);
      logic [34:0] g;
      case (dig)
         0:       g = {7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E};
         1:       g = {7'h00, 7'h42, 7'h7F, 7'h40, 7'h00};
         2:       g = {7'h72, 7'h49, 7'h49, 7'h49, 7'h46};
         3:       g = {7'h21, 7'h41, 7'h45, 7'h4B, 7'h31};
         4:       g = {7'h0F, 7'h08, 7'h08, 7'h7F, 7'h08};
         5:       g = {7'h27, 7'h45, 7'h45, 7'h45, 7'h39};
         6:       g = {7'h3A, 7'h45, 7'h45, 7'h45, 7'h38};
         7:       g = {7'h01, 7'h01, 7'h71, 7'h09, 7'h07};
         8:       g = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
         default: g = {7'h26, 7'h49, 7'h49, 7'h49, 7'h3E};
      endcase
      return g[34 - 7 * c -: 7];
   endfunction

   // queue the 64 columns a new timecode produces; a repeat produces none
   task automatic render_timecode(input timecode_type raw);
      timecode_type     sat;
      logic [TC_W-1:0]  tc_word;
      logic [ROW_W-1:0] layout [64];
      column_type       col_item;
      int               col, k, c, v, dig;
      for (k = 0; k < NUM_FLD; k++)
         sat[k] = (raw[k] > FIELD_MAX) ? FIELD_MAX : raw[k];
      tc_word = {sat[0], sat[1], sat[2], sat[3], sat[4]};
      if (shown_ok && tc_word == shown_tc)
         return;
      shown_tc = tc_word;
      shown_ok = 1'b1;
      for (k = 0; k < 64; k++)
         layout[k] = '0;
      col = 1;
      for (k = 0; k < NUM_DIG; k++) begin
         v = int'(sat[k / 2]);
         dig = (k % 2 == 0) ? v / 10 : v % 10;
         for (c = 0; c < 5; c++)
            layout[col + c] = glyph_column(dig, c);
         col += 5;
         if (k == 1 || k == 3 || k == 5 || k == 7) begin
            layout[col + 1] = (k == 7) ? SEP_DOT : SEP_COLON;
            col += 3;
         end
      end
      for (k = 0; k < 64; k++) begin
         col_item.index = k[COL_IDX_W-1:0];
         col_item.bits  = layout[63 - k];
         col_item.last  = (k == 63);
         expected_columns.push_back(col_item);
      end
   endtask

   task automatic add_timecode(input int d, input int h, input int m, input int s,
                               input int f, input logic drain);
      tc_item_type it;
      it.fld[0] = d[6:0];
      it.fld[1] = h[6:0];
      it.fld[2] = m[6:0];
      it.fld[3] = s[6:0];
      it.fld[4] = f[6:0];
      it.drain  = drain;
      pending_items.push_back(it);
   endtask

   function automatic logic [FIELD_W-1:0] random_field();
      if ($urandom_range(0, 3) == 0)
         return FIELD_W'($urandom_range(0, 127));
      return FIELD_W'($urandom_range(0, 99));
   endfunction

   // sender: one item in flight, random gap after each transfer, no gap after items 38 to 49 of every 50
   always @(negedge clock) begin
      tc_item_type nxt;
      logic        nv;
      nv = req_tvalid;
      if (reset) begin
         nv = 1'b0;
      end else begin
         if (nv && req_accepts == req_sent) begin
            nv = 1'b0;
            tx_gap = ((req_sent % 50) >= 38) ? 0 : $urandom_range(0, 5);
         end
         if (!nv) begin
            if (tx_gap > 0) begin
               tx_gap--;
            end else if (pending_items.size() != 0 &&
                         !(pending_items[0].drain && expected_columns.size() != 0)) begin
               nxt = pending_items.pop_front();
               req_tdata <= {5'b0, nxt.fld};
               req_sent++;
               nv = 1'b1;
            end
         end
      end
      req_tvalid <= nv;
   end

   // receiver: random wait after each transfer, none in every third run of 300 transfers, one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_seen != rsp_transfers) begin
            rsp_seen = rsp_transfers;
            rx_wait = (((rsp_transfers / 300) % 3) == 2) ? 0 : $urandom_range(0, 5);
            if (rsp_transfers == LONG_HOLD_AT)
               rx_wait = LONG_HOLD;
         end
         if (rx_wait > 0) begin
            rx_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // predict on input transfers, check output transfers
   always @(posedge clock) begin
      column_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            render_timecode(req_tdata[TC_W-1:0]);
            req_accepts++;
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_transfers++;
            if (expected_columns.size() == 0) begin
               $error("unexpected column transfer, column_index %0d", rsp_tdata[5:0]);
               fails++;
            end else begin
               want = expected_columns.pop_front();
               if (rsp_tdata[5:0] !== want.index) begin
                  $error("column_index expected %0d actual %0d", want.index, rsp_tdata[5:0]);
                  fails++;
               end
               if (rsp_tdata[12:6] !== want.bits) begin
                  $error("column_bits expected 0x%02h actual 0x%02h", want.bits,
                         rsp_tdata[12:6]);
                  fails++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last_column expected %0b actual %0b", want.last, rsp_tlast);
                  fails++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      timecode_type cur;
      int           n, k, r, v;
      logic         carry;

      // directed: first render, repeats, saturation, every digit, bit extremes
      add_timecode(0, 0, 0, 0, 0, 1'b0);
      add_timecode(0, 0, 0, 0, 0, 1'b0);
      add_timecode(99, 99, 99, 99, 99, 1'b0);
      add_timecode(127, 127, 127, 127, 127, 1'b0);
      add_timecode(100, 99, 101, 99, 126, 1'b0);
      add_timecode(12, 34, 56, 78, 90, 1'b0);
      add_timecode(98, 76, 54, 32, 10, 1'b1);
      add_timecode(0, 0, 0, 0, 0, 1'b0);
      add_timecode(64, 64, 64, 64, 64, 1'b0);
      add_timecode(63, 63, 63, 63, 63, 1'b0);
      add_timecode(99, 0, 99, 0, 99, 1'b0);
      add_timecode(0, 99, 0, 99, 0, 1'b1);
      add_timecode(1, 23, 45, 67, 89, 1'b0);
      add_timecode(1, 23, 45, 67, 89, 1'b0);
      add_timecode(11, 22, 33, 44, 55, 1'b0);
      add_timecode(66, 77, 88, 99, 0, 1'b0);
      add_timecode(127, 0, 0, 0, 0, 1'b0);
      add_timecode(0, 0, 0, 0, 127, 1'b0);
      add_timecode(100, 100, 100, 100, 100, 1'b0);

      // random: mostly a running timecode, with repeats and jumps
      for (k = 0; k < NUM_FLD; k++)
         cur[k] = random_field();
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         r = $urandom_range(0, 9);
         if (r < 2) begin
            for (k = 0; k < NUM_FLD; k++)
               if (cur[k] >= FIELD_MAX && $urandom_range(0, 1) == 1)
                  cur[k] = FIELD_W'($urandom_range(99, 127));
         end else if (r < 7) begin
            carry = 1'b1;
            for (k = NUM_FLD - 1; k >= 0; k--) begin
               v = (cur[k] > FIELD_MAX) ? 99 : int'(cur[k]);
               if (carry) begin
                  v++;
                  carry = (v == 100);
                  if (carry)
                     v = 0;
               end
               cur[k] = v[6:0];
            end
         end else begin
            for (k = 0; k < NUM_FLD; k++)
               cur[k] = random_field();
         end
         add_timecode(cur[0], cur[1], cur[2], cur[3], cur[4], $urandom_range(0, 29) == 0);
      end

      repeat (12) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      while (pending_items.size() != 0 || req_accepts != req_sent)
         @(posedge clock);
      while (expected_columns.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (expected_columns.size() != 0) begin
         $error("columns still expected at end: %0d", expected_columns.size());
         fails++;
      end
      if (fails == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
